@@ hw/rtl/hsc_pkg.sv @@
// Shared constants, types and parity functions for the Hamming SEC codec.
package hsc_pkg;

    localparam int MAX_DATA_BITS = 26;
    localparam int DATA_W        = MAX_DATA_BITS;
    localparam int POS_W         = 5;
    localparam int CODE_W        = 31;
    localparam int CFG_W         = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_BEYOND    = 2'd2
    } t_status;

    // Derived code geometry, refreshed on every register write.
    typedef struct packed {
        logic [POS_W-1:0]  shamt;   // DATA_W - m
        logic [POS_W-1:0]  n;       // code length m + r
        logic [CODE_W-1:0] nmask;   // ones at positions 1..n
    } t_cfg;

    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // XOR of the positions of all set bits: one parity tree per syndrome bit.
    function automatic logic [POS_W-1:0] syndrome(input logic [CODE_W-1:0] word);
        logic [POS_W-1:0] s;
        s = '0;
        for (int b = 0; b < POS_W; b++) begin
            for (int p = 1; p <= CODE_W; p++) begin
                if (((p >> b) & 1) == 1) begin
                    s[b] = s[b] ^ word[p-1];
                end
            end
        end
        return s;
    endfunction

    // Map a raw register value to the code geometry.
    function automatic t_cfg cfg_decode(input logic [CFG_W-1:0] raw);
        t_cfg        c;
        int          m;
        int          r_cnt;
        logic [31:0] mask32;
        m = int'(raw);
        if (m == 0) begin
            m = 1;
        end
        if (m > MAX_DATA_BITS) begin
            m = MAX_DATA_BITS;
        end
        r_cnt = POS_W + 1;
        for (int r = POS_W + 1; r >= 0; r--) begin
            if ((1 << r) >= (m + r + 1)) begin
                r_cnt = r;
            end
        end
        mask32  = (32'd1 << (m + r_cnt)) - 32'd1;
        c.shamt = POS_W'(DATA_W - m);
        c.n     = POS_W'(m + r_cnt);
        c.nmask = mask32[CODE_W-1:0];
        return c;
    endfunction

endpackage

@@ hw/rtl/hsc_cfg_regs.sv @@
// Configuration register: data bit count, held as decoded code geometry.
module hsc_cfg_regs
    import hsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            n_cfg = cfg_decode(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cfg_decode(CFG_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/hsc_encode.sv @@
// Encoder: scatter data bits to non-power-of-two positions, then fill parity.
module hsc_encode
    import hsc_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [DATA_W-1:0] i_data_word,
    output logic [CODE_W-1:0] o_code_word
);

    logic [DATA_W-1:0] shifted;
    logic [CODE_W-1:0] word;
    logic [POS_W-1:0]  s;
    int                j;

    always_comb begin
        // Align data index m-1 to the top; indices m and above fall off.
        shifted = i_data_word << i_cfg.shamt;
        word    = '0;
        j       = 0;
        for (int p = 1; p <= CODE_W; p++) begin
            if (!is_pow2(p)) begin
                word[p-1] = shifted[DATA_W-1-j];
                j         = j + 1;
            end
        end
        s = syndrome(word);
        // Parity bit at 2^i clears syndrome bit i.
        for (int i = 0; i < POS_W; i++) begin
            word[(1 << i) - 1] = s[i];
        end
        o_code_word = word;
    end

endmodule

@@ hw/rtl/hsc_check.sv @@
// Checker: syndrome of the received word and single-bit correction.
module hsc_check
    import hsc_pkg::*;
(
    input  t_cfg              i_cfg,
    input  logic [CODE_W-1:0] i_received_code,
    output logic [CODE_W-1:0] o_code_word,
    output logic [POS_W-1:0]  o_error_position,
    output t_status           o_error_status
);

    logic [CODE_W-1:0] masked;
    logic [POS_W-1:0]  s;

    always_comb begin
        masked           = i_received_code & i_cfg.nmask;
        s                = syndrome(masked);
        o_code_word      = masked;
        o_error_position = s;
        o_error_status   = ST_OK;
        if (s != '0) begin
            if (s <= i_cfg.n) begin
                o_code_word    = masked ^ (CODE_W'(1) << (s - POS_W'(1)));
                o_error_status = ST_CORRECTED;
            end else begin
                o_error_status = ST_BEYOND;
            end
        end
    end

endmodule

@@ hw/rtl/hamming_sec_codec_unit.sv @@
// Hamming SEC codec top level: request register, encode/check logic, result register.
// A request passes through the request register, then the result register.
// One request per cycle unless stalled; parity trees sit between the two registers.
// A new request is taken while a result waits only if the request register is empty.
// Reset (synchronous, active low): data bit count returns to 4, both stages empty.
// User must drain the pipeline before configuration writes; the block does not check.
module hamming_sec_codec_unit
    import hsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_func,
    input  logic [DATA_W-1:0] i_data_word,
    input  logic [CODE_W-1:0] i_received_code,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_code_word,
    output logic [POS_W-1:0]  o_error_position,
    output logic [1:0]        o_error_status
);

    t_cfg cfg;

    // Request stage
    logic              r_in_valid;
    logic              r_func;
    logic [DATA_W-1:0] r_data_word;
    logic [CODE_W-1:0] r_received_code;

    // Result stage
    logic              r_out_valid;
    logic [CODE_W-1:0] r_code_word;
    logic [POS_W-1:0]  r_error_position;
    t_status           r_error_status;

    logic [CODE_W-1:0] n_code_word;
    logic [POS_W-1:0]  n_error_position;
    t_status           n_error_status;

    logic [CODE_W-1:0] enc_word;
    logic [CODE_W-1:0] chk_word;
    logic [POS_W-1:0]  chk_pos;
    t_status           chk_status;

    logic out_load;
    logic in_load;

    hsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    hsc_encode u_enc (
        .i_cfg       (cfg),
        .i_data_word (r_data_word),
        .o_code_word (enc_word)
    );

    hsc_check u_chk (
        .i_cfg            (cfg),
        .i_received_code  (r_received_code),
        .o_code_word      (chk_word),
        .o_error_position (chk_pos),
        .o_error_status   (chk_status)
    );

    // Result register loads when empty or when its result is being taken;
    // the request register loads when empty or when it moves forward.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || out_load;
    assign o_in_stall = !in_load;

    // Select the result of the requested function; encode reports no error.
    always_comb begin
        case (r_func)
            FUNC_ENCODE: begin
                n_code_word      = enc_word;
                n_error_position = '0;
                n_error_status   = ST_OK;
            end
            FUNC_CHECK: begin
                n_code_word      = chk_word;
                n_error_position = chk_pos;
                n_error_status   = chk_status;
            end
            default: begin
                n_code_word      = enc_word;
                n_error_position = '0;
                n_error_status   = ST_OK;
            end
        endcase
    end

    // Control: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_func          <= i_func;
            r_data_word     <= i_data_word;
            r_received_code <= i_received_code;
        end
        if (out_load) begin
            r_code_word      <= n_code_word;
            r_error_position <= n_error_position;
            r_error_status   <= n_error_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_code_word      = r_code_word;
    assign o_error_position = r_error_position;
    assign o_error_status   = r_error_status;

`ifndef NO_ASSERTIONS
    // Any delivered word other than a flagged one is a valid code word.
    a_zero_syndrome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error_status != ST_BEYOND) |-> (syndrome(r_code_word) == '0))
        else $error("result word has nonzero syndrome");

    // Nothing is delivered above the code length.
    a_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_code_word & ~cfg.nmask) == '0))
        else $error("result word has bits above code length");

    // A clean result reports position zero.
    a_ok_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error_status == ST_OK) |-> (r_error_position == '0))
        else $error("clean result with nonzero error position");

    // A flagged syndrome really lies beyond the code length.
    a_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_error_status == ST_BEYOND) |-> (r_error_position > cfg.n))
        else $error("out-of-range flag with in-range syndrome");

    // Requests are held off only when both stages are full and the output is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("request stalled with room in the pipeline");
`endif

endmodule
